// ===== src/asrd_pkg.sv =====
// ----------------------------------------------------------------------------
// asrd_pkg: shared types and constants for the stick shaping pipeline
// Fixed-point format, stage map, register indexes and the records that
// travel down the row of cells.
// ----------------------------------------------------------------------------
package asrd_pkg;

	// Q2.14 fixed point: full deflection is 1 << FRAC_BITS.
	localparam int FRAC_BITS = 14;
	localparam logic [14:0] ONE_Q = 15'(1 << FRAC_BITS);
	localparam logic [14:0] ONE_M1_Q = 15'((1 << FRAC_BITS) - 1);

	// Cells in each chain.
	localparam int N_SQRT = 16;
	localparam int N_DIV1 = 14;
	localparam int N_DIV2 = 15;

	// Stage map of the whole pipeline.
	localparam int ST_SUM = 1;
	localparam int ST_SQ0 = 2;
	localparam int ST_R = ST_SQ0 + N_SQRT;
	localparam int ST_D1 = ST_R + 1;
	localparam int ST_M0 = ST_D1 + N_DIV1;
	localparam int ST_M = ST_M0 + 1;
	localparam int ST_P = ST_M + 1;
	localparam int ST_D2 = ST_P + 1;
	localparam int ST_OUT = ST_D2 + N_DIV2;
	localparam int N_ST = ST_OUT + 1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_CIRCULAR = 2'd0,
		REG_DEAD_ZONE = 2'd1,
		REG_INV_DEAD_ZONE = 2'd2,
		REG_SENSITIVITY = 2'd3
	} cfg_reg_t;

	// Per-sample side data that rides along every stage.
	typedef struct packed {
		logic sx;
		logic sy;
		logic [16:0] ax;
		logic [16:0] ay;
		logic [16:0] c;
		logic zero;
		logic mz;
		logic sat;
		logic [14:0] m;
	} rider_t;

	// Digit-pair square root step state.
	typedef struct packed {
		logic [31:0] rad;
		logic [17:0] rem;
		logic [15:0] root;
	} sqrt_t;

	// Restoring division step state.
	typedef struct packed {
		logic [16:0] rem;
		logic [16:0] den;
		logic [14:0] num;
		logic [14:0] quo;
	} div_t;

endpackage

// ===== src/asrd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// asrd_sqrt_cell: one step of the integer square root
// Brings in the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module asrd_sqrt_cell (
	input logic clk,
	input logic en,
	input asrd_pkg::sqrt_t d,
	output asrd_pkg::sqrt_t q
);
	import asrd_pkg::*;

	sqrt_t nx;
	logic [19:0] part;
	logic [19:0] trial;

	// Trial subtraction of (4 * root + 1) from the extended remainder.
	always_comb begin
		part = {d.rem, d.rad[31:30]};
		trial = {2'b00, d.root, 2'b01};
		nx.rad = {d.rad[29:0], 2'b00};
		if (part >= trial) begin
			nx.rem = 18'(part - trial);
			nx.root = {d.root[14:0], 1'b1};
		end else begin
			nx.rem = part[17:0];
			nx.root = {d.root[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end

endmodule

// ===== src/asrd_div_cell.sv =====
// ----------------------------------------------------------------------------
// asrd_div_cell: one step of restoring division
// Shifts in the next numerator bit and decides one quotient bit.
// ----------------------------------------------------------------------------
module asrd_div_cell (
	input logic clk,
	input logic en,
	input asrd_pkg::div_t d,
	output asrd_pkg::div_t q
);
	import asrd_pkg::*;

	div_t nx;
	logic [17:0] part;

	// The remainder stays below the divisor, so one compare settles the bit.
	always_comb begin
		part = {d.rem, d.num[14]};
		nx.den = d.den;
		nx.num = {d.num[13:0], 1'b0};
		if (part >= {1'b0, d.den}) begin
			nx.rem = 17'(part - {1'b0, d.den});
			nx.quo = {d.quo[13:0], 1'b1};
		end else begin
			nx.rem = part[16:0];
			nx.quo = {d.quo[13:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end

endmodule

// ===== src/analog_stick_radial_deadzone_top.sv =====
// ----------------------------------------------------------------------------
// analog_stick_radial_deadzone_top: radial dead zone and sensitivity shaping
// Usage notes:
// One stick sample enters per beat on the s_ channel (stick_x in bits 15:0,
// stick_y in bits 31:16, Q2.14) and one shaped sample leaves per beat on
// the m_ channel in the same layout. The block is a row of 52 register
// stages: an input stage, a radius sum, 16 square root cells, a dead zone
// stage, 14 divider cells, two sensitivity stages, a product stage, 15
// divider cells per axis and the output register. Throughput is one
// sample per cycle while the receiver holds m_tready high.
// Each stage hands its beat on whenever the next stage is empty or moving,
// so a stalled receiver first fills the empty stages and s_tready falls
// only once every stage holds a beat. The cfg_ port writes one register
// per cycle; write it only while no sample is in flight.
// Reset clears all stage valid flags and loads the default registers:
// square mode, dead zone 2458, inverse dead zone 0, sensitivity 16384.
// ----------------------------------------------------------------------------
module analog_stick_radial_deadzone_top (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata,   // stick_x [15:0], stick_y [31:16]
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata,  // shaped_x [15:0], shaped_y [31:16]
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [14:0] cfg_data
);
	import asrd_pkg::*;

	logic cfg_circ_q;
	logic [13:0] cfg_dz_q;
	logic [14:0] cfg_inv_q;
	logic [14:0] cfg_sens_q;

	logic valid_q [N_ST];
	logic ready [N_ST + 1];
	logic vin [N_ST];
	rider_t rider_q [N_ST];
	rider_t rider_d [N_ST];

	logic [31:0] sq_x_s1;
	logic [31:0] sq_y_s1;
	sqrt_t sq_q [N_SQRT + 1];
	div_t d1_q [N_DIV1 + 1];
	logic signed [30:0] prod_q;
	div_t dx_q [N_DIV2 + 1];
	div_t dy_q [N_DIV2 + 1];
	logic [15:0] out_x_q;
	logic [15:0] out_y_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_circ_q <= 1'b0;
			cfg_dz_q <= 14'd2458;
			cfg_inv_q <= 15'd0;
			cfg_sens_q <= 15'd16384;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CIRCULAR: cfg_circ_q <= cfg_data[0];
				REG_DEAD_ZONE: cfg_dz_q <= cfg_data[13:0];
				REG_INV_DEAD_ZONE: cfg_inv_q <= cfg_data;
				REG_SENSITIVITY: cfg_sens_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: a stage loads when it is empty or its successor moves.
	always_comb begin
		ready[N_ST] = m_tready;
		for (int k = N_ST - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k + 1];
		end
		vin[0] = s_tvalid;
		for (int k = 1; k < N_ST; k++) begin
			vin[k] = valid_q[k - 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N_ST; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < N_ST; k++) begin
				if (ready[k]) begin
					valid_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = ready[0];

	// Input stage: magnitudes, signs and the larger component.
	logic signed [16:0] xs_c;
	logic signed [16:0] ys_c;
	logic [16:0] ax_c;
	logic [16:0] ay_c;
	logic [33:0] x2_c;
	logic [33:0] y2_c;

	always_comb begin
		xs_c = $signed({s_tdata[15], s_tdata[15:0]});
		ys_c = $signed({s_tdata[31], s_tdata[31:16]});
		ax_c = xs_c[16] ? 17'(-xs_c) : 17'(xs_c);
		ay_c = ys_c[16] ? 17'(-ys_c) : 17'(ys_c);
		x2_c = ax_c * ax_c;
		y2_c = ay_c * ay_c;
	end

	always_ff @(posedge clk) begin
		if (ready[0]) begin
			sq_x_s1 <= x2_c[31:0];
			sq_y_s1 <= y2_c[31:0];
		end
	end

	// Dead zone stage signals.
	logic [15:0] r_c;
	logic [16:0] den_c;
	logic [16:0] diff_c;
	logic mz_c;
	logic sat_c;

	always_comb begin
		r_c = cfg_circ_q ? sq_q[N_SQRT].root : rider_q[ST_R - 1].c[15:0];
		// The 14-bit dead zone never reaches one, so the divisor is at least 1.
		den_c = 17'(ONE_Q) - {3'b000, cfg_dz_q};
		diff_c = {1'b0, r_c} - {3'b000, cfg_dz_q};
		mz_c = (r_c <= {2'b00, cfg_dz_q});
		sat_c = !mz_c && (diff_c >= den_c);
	end

	// Sensitivity stage signals.
	logic [14:0] m0_c;
	logic signed [16:0] delta_c;
	logic signed [33:0] prod_c;
	logic signed [30:0] bias_c;
	logic signed [30:0] t_c;
	logic signed [31:0] msum_c;
	logic [14:0] m_c;

	always_comb begin
		if (rider_q[ST_M0 - 1].mz) begin
			m0_c = 15'd0;
		end else if (rider_q[ST_M0 - 1].sat) begin
			m0_c = ONE_Q;
		end else begin
			m0_c = {1'b0, d1_q[N_DIV1].quo[13:0]};
		end
		delta_c = $signed({2'b00, cfg_sens_q}) - $signed({2'b00, cfg_inv_q});
		prod_c = $signed({2'b00, m0_c}) * delta_c;
		// Division by one in Q2.14 truncates toward zero.
		bias_c = prod_q + (prod_q[30] ? $signed(31'(ONE_M1_Q)) : 31'sd0);
		t_c = bias_c >>> FRAC_BITS;
		msum_c = $signed({17'd0, cfg_inv_q}) + 32'(t_c);
		if (rider_q[ST_M - 1].mz || msum_c < 32'sd0) begin
			m_c = 15'd0;
		end else if (msum_c > $signed({17'd0, ONE_Q})) begin
			m_c = ONE_Q;
		end else begin
			m_c = msum_c[14:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ready[ST_M0]) begin
			prod_q <= prod_c[30:0];
		end
	end

	// Side data updates along the row.
	always_comb begin
		rider_d[0].sx = xs_c[16];
		rider_d[0].sy = ys_c[16];
		rider_d[0].ax = ax_c;
		rider_d[0].ay = ay_c;
		rider_d[0].c = (ax_c > ay_c) ? ax_c : ay_c;
		rider_d[0].zero = (ax_c == 17'd0) && (ay_c == 17'd0);
		rider_d[0].mz = 1'b0;
		rider_d[0].sat = 1'b0;
		rider_d[0].m = 15'd0;
		for (int k = 1; k < N_ST; k++) begin
			rider_d[k] = rider_q[k - 1];
		end
		rider_d[ST_R].mz = mz_c;
		rider_d[ST_R].sat = sat_c;
		rider_d[ST_M0].mz = (m0_c == 15'd0);
		rider_d[ST_M].m = m_c;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_ST; k++) begin
			if (ready[k]) begin
				rider_q[k] <= rider_d[k];
			end
		end
	end

	// Square root chain.
	always_ff @(posedge clk) begin
		if (ready[ST_SUM]) begin
			sq_q[0].rad <= sq_x_s1 + sq_y_s1;
			sq_q[0].rem <= 18'd0;
			sq_q[0].root <= 16'd0;
		end
	end

	for (genvar i = 0; i < N_SQRT; i++) begin : g_sqrt
		asrd_sqrt_cell u_cell (
			.clk(clk),
			.en(ready[ST_SQ0 + i]),
			.d(sq_q[i]),
			.q(sq_q[i + 1])
		);
	end

	// Dead zone rescale chain.
	always_ff @(posedge clk) begin
		if (ready[ST_R]) begin
			d1_q[0].rem <= (mz_c || sat_c) ? 17'd0 : diff_c;
			d1_q[0].den <= den_c;
			d1_q[0].num <= 15'd0;
			d1_q[0].quo <= 15'd0;
		end
	end

	for (genvar i = 0; i < N_DIV1; i++) begin : g_div1
		asrd_div_cell u_cell (
			.clk(clk),
			.en(ready[ST_D1 + i]),
			.d(d1_q[i]),
			.q(d1_q[i + 1])
		);
	end

	// Component scaling: component * m, then divided by c per axis.
	logic [31:0] px_c;
	logic [31:0] py_c;

	always_comb begin
		px_c = rider_q[ST_P - 1].ax * rider_q[ST_P - 1].m;
		py_c = rider_q[ST_P - 1].ay * rider_q[ST_P - 1].m;
	end

	always_ff @(posedge clk) begin
		if (ready[ST_P]) begin
			dx_q[0].rem <= {2'b00, px_c[29:15]};
			dx_q[0].num <= px_c[14:0];
			dx_q[0].den <= rider_q[ST_P - 1].c;
			dx_q[0].quo <= 15'd0;
			dy_q[0].rem <= {2'b00, py_c[29:15]};
			dy_q[0].num <= py_c[14:0];
			dy_q[0].den <= rider_q[ST_P - 1].c;
			dy_q[0].quo <= 15'd0;
		end
	end

	for (genvar i = 0; i < N_DIV2; i++) begin : g_div2
		asrd_div_cell u_cell_x (
			.clk(clk),
			.en(ready[ST_D2 + i]),
			.d(dx_q[i]),
			.q(dx_q[i + 1])
		);
		asrd_div_cell u_cell_y (
			.clk(clk),
			.en(ready[ST_D2 + i]),
			.d(dy_q[i]),
			.q(dy_q[i + 1])
		);
	end

	// Output register: restore signs; a centered stick gives zero.
	rider_t last_c;
	logic [15:0] qx_c;
	logic [15:0] qy_c;

	always_comb begin
		last_c = rider_q[ST_OUT - 1];
		qx_c = {1'b0, dx_q[N_DIV2].quo};
		qy_c = {1'b0, dy_q[N_DIV2].quo};
	end

	always_ff @(posedge clk) begin
		if (ready[ST_OUT]) begin
			out_x_q <= last_c.zero ? 16'd0 : (last_c.sx ? 16'(-qx_c) : qx_c);
			out_y_q <= last_c.zero ? 16'd0 : (last_c.sy ? 16'(-qy_c) : qy_c);
		end
	end

	assign m_tvalid = valid_q[ST_OUT];
	assign m_tdata = {out_y_q, out_x_q};

	// Shaped components stay within plus or minus one.
	a_out_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= $signed({1'b0, ONE_Q}) &&
			$signed(m_tdata[15:0]) >= -$signed({1'b0, ONE_Q})))
		else $error("shaped_x out of range");

	a_out_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:16]) <= $signed({1'b0, ONE_Q}) &&
			$signed(m_tdata[31:16]) >= -$signed({1'b0, ONE_Q})))
		else $error("shaped_y out of range");

	// The shaped magnitude never exceeds one.
	a_m_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[ST_M] |-> rider_q[ST_M].m <= ONE_Q)
		else $error("magnitude above one");

	// An accepted beat occupies the first stage on the next edge.
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_q[0])
		else $error("accepted beat lost at the input stage");

endmodule
